@@ src/line_follow_pid_duty_top_defines.svh @@
// Assertion macros for the line follower PID duty block.
// LFPD_ASSERT is disabled while reset is asserted; LFPD_ASSERT_ALWAYS also
// holds during reset.
`ifndef LINE_FOLLOW_PID_DUTY_TOP_DEFINES_SVH
`define LINE_FOLLOW_PID_DUTY_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define LFPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define LFPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define LFPD_ASSERT(lbl, prop, msg)

`define LFPD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ src/lfpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

  // Field and datapath widths
  localparam int unsigned SensW = 5;
  localparam int unsigned GainW = 4;
  localparam int unsigned DutyW = 7;
  localparam int unsigned LimW  = 7;
  localparam int unsigned ErrW  = 6;   // scaled error, signed
  localparam int unsigned SumW  = 8;   // running sum, signed
  localparam int unsigned SumXW = 9;   // sum plus error before saturation
  localparam int unsigned CorrW = 15;  // correction and duty before clamp
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register reset values
  localparam logic [GainW-1:0] GainPRst      = 4'd3;
  localparam logic [GainW-1:0] GainIRst      = 4'd0;
  localparam logic [GainW-1:0] GainDRst      = 4'd1;
  localparam logic [DutyW-1:0] BaseDutyRst   = 7'd55;
  localparam logic [DutyW-1:0] DutyFloorRst  = 7'd70;
  localparam logic [DutyW-1:0] DutyCeilRst   = 7'd85;
  localparam logic [LimW-1:0]  SumLimitRst   = 7'd30;

  // Scaled error values
  localparam logic signed [ErrW-1:0] ErrAllDark = 6'sd25;
  localparam logic signed [ErrW-1:0] ErrSide    = 6'sd10;

  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_BASE_DUTY    = 3'd3,
    REG_DUTY_FLOOR   = 3'd4,
    REG_DUTY_CEILING = 3'd5,
    REG_SUM_LIMIT    = 3'd6
  } cfg_reg_e;

  // Error from the sensor pattern; first match wins
  function automatic logic signed [ErrW-1:0] pick_error(
    input logic [SensW-1:0] bits,
    input logic             last_neg
  );
    logic signed [ErrW-1:0] err;
    if (bits == '0) begin
      err = last_neg ? -ErrAllDark : ErrAllDark;
    end else if (!bits[1] && bits[3]) begin
      err = -ErrSide;
    end else if (bits[1] && !bits[3]) begin
      err = ErrSide;
    end else begin
      err = '0;
    end
    return err;
  endfunction

  // Upper bound is tested first, so floor above ceiling still resolves
  function automatic logic signed [CorrW-1:0] clamp_hi_first(
    input logic signed [CorrW-1:0] v,
    input logic signed [CorrW-1:0] lo,
    input logic signed [CorrW-1:0] hi
  );
    logic signed [CorrW-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/line_follow_pid_duty_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// PID steering for a five-sensor line follower.
// Input channel: one request per sensor sample on sensor_bits_i, taken at an
// edge with in_valid_i high and in_stall_o low.
// Output channel: left_duty_o / right_duty_o, handed over at an edge with
// out_valid_o high and out_stall_i low.
// Path: a taken request waits in the input register and moves, once the result
// register is free, into the result register together with its duties.
// Throughput: one request per cycle unless out_stall_i holds the result; the
// whole error/sum/PID/clamp step sits between the input and result registers.
// Reset (rst_ni low, asynchronous): both stages empty, last error and the
// running sum cleared, all registers back to their defaults.
// Receiver stall: the result register holds its duties; the input stage
// carries on while the result register is free, and in_stall_o rises only
// when both stages hold a request.
// APB registers at 4*i: gain_p, gain_i, gain_d, base_duty, duty_floor,
// duty_ceiling, sum_limit. Write them only while the block is idle.
`include "line_follow_pid_duty_top_defines.svh"

module line_follow_pid_duty_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // sample channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [lfpd_pkg::SensW-1:0] sensor_bits_i,
  // duty channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [lfpd_pkg::DutyW-1:0]      left_duty_o,
  output logic [lfpd_pkg::DutyW-1:0]      right_duty_o,
  // register port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lfpd_pkg::AddrW-1:0] paddr,
  input  wire logic [lfpd_pkg::DataW-1:0] pwdata,
  output logic [lfpd_pkg::DataW-1:0]      prdata,
  output logic                            pready
);
  import lfpd_pkg::*;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  logic [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [DutyW-1:0] base_duty_q, duty_floor_q, duty_ceiling_q;
  logic [LimW-1:0]  sum_limit_q;
  logic             cfg_wr;
  cfg_reg_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= GainPRst;
      gain_i_q       <= GainIRst;
      gain_d_q       <= GainDRst;
      base_duty_q    <= BaseDutyRst;
      duty_floor_q   <= DutyFloorRst;
      duty_ceiling_q <= DutyCeilRst;
      sum_limit_q    <= SumLimitRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_P:       gain_p_q       <= pwdata[GainW-1:0];
        REG_GAIN_I:       gain_i_q       <= pwdata[GainW-1:0];
        REG_GAIN_D:       gain_d_q       <= pwdata[GainW-1:0];
        REG_BASE_DUTY:    base_duty_q    <= pwdata[DutyW-1:0];
        REG_DUTY_FLOOR:   duty_floor_q   <= pwdata[DutyW-1:0];
        REG_DUTY_CEILING: duty_ceiling_q <= pwdata[DutyW-1:0];
        REG_SUM_LIMIT:    sum_limit_q    <= pwdata[LimW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_P:       prdata = DataW'(gain_p_q);
      REG_GAIN_I:       prdata = DataW'(gain_i_q);
      REG_GAIN_D:       prdata = DataW'(gain_d_q);
      REG_BASE_DUTY:    prdata = DataW'(base_duty_q);
      REG_DUTY_FLOOR:   prdata = DataW'(duty_floor_q);
      REG_DUTY_CEILING: prdata = DataW'(duty_ceiling_q);
      REG_SUM_LIMIT:    prdata = DataW'(sum_limit_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: input stage and result stage
  // ---------------------------------------------------------------------
  logic             in_vld_q, in_vld_d;
  logic [SensW-1:0] sens_q;
  logic             out_vld_q, out_vld_d;
  logic             in_take;
  logic             adv;   // input stage moves into the result register

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sens_q <= sensor_bits_i;
    end
  end

  // ---------------------------------------------------------------------
  // Error, running sum and PID step
  // ---------------------------------------------------------------------
  logic signed [ErrW-1:0]  last_err_q, err;
  logic signed [SumW-1:0]  err_sum_q, err_sum_d;
  logic signed [SumXW-1:0] sum_raw, lim_pos;
  logic signed [CorrW-1:0] gp_x, gi_x, gd_x, err_x, sum_x, diff_x;
  logic signed [CorrW-1:0] p_term, i_term, d_term, corr;
  logic signed [CorrW-1:0] base_x, floor_x, ceil_x;
  logic signed [CorrW-1:0] left_raw, right_raw, left_cl, right_cl;

  assign err = pick_error(sens_q, last_err_q[ErrW-1]);

  // saturate the running sum to +/- sum_limit, upper bound first
  assign lim_pos = $signed(SumXW'(sum_limit_q));
  assign sum_raw = SumXW'(err_sum_q) + SumXW'(err);
  always_comb begin
    if (sum_raw > lim_pos) begin
      err_sum_d = SumW'(lim_pos);
    end else if (sum_raw < -lim_pos) begin
      err_sum_d = SumW'(-lim_pos);
    end else begin
      err_sum_d = SumW'(sum_raw);
    end
  end

  assign gp_x   = $signed(CorrW'(gain_p_q));
  assign gi_x   = $signed(CorrW'(gain_i_q));
  assign gd_x   = $signed(CorrW'(gain_d_q));
  assign err_x  = CorrW'(err);
  assign sum_x  = CorrW'(err_sum_d);
  assign diff_x = CorrW'(err) - CorrW'(last_err_q);

  assign p_term = gp_x * err_x;
  assign i_term = gi_x * sum_x;
  assign d_term = gd_x * diff_x;
  assign corr   = p_term + i_term + d_term;

  assign base_x  = $signed(CorrW'(base_duty_q));
  assign floor_x = $signed(CorrW'(duty_floor_q));
  assign ceil_x  = $signed(CorrW'(duty_ceiling_q));

  assign left_raw  = base_x - corr;
  assign right_raw = base_x + corr;
  assign left_cl   = clamp_hi_first(left_raw, floor_x, ceil_x);
  assign right_cl  = clamp_hi_first(right_raw, floor_x, ceil_x);

  // state moves only with the request it belongs to
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      err_sum_q  <= '0;
    end else if (adv) begin
      last_err_q <= err;
      err_sum_q  <= err_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      left_duty_o  <= left_cl[DutyW-1:0];
      right_duty_o <= right_cl[DutyW-1:0];
    end
  end

  assign out_valid_o = out_vld_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `LFPD_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> in_vld_q, "stall with empty input stage")
  `LFPD_ASSERT(a_last_err_legal, (last_err_q == 6'sd0) || (last_err_q == ErrSide) || (last_err_q == -ErrSide) || (last_err_q == ErrAllDark) || (last_err_q == -ErrAllDark), "illegal last error")
  `LFPD_ASSERT(a_state_holds, !adv |=> ($stable(err_sum_q) && $stable(last_err_q)), "state moved without a request")
  `LFPD_ASSERT(a_result_from_stage, $rose(out_vld_q) |-> $past(adv), "result without a request")

endmodule

`default_nettype wire
